/* sv/fmpf_pkg.sv */
// ----------------------------------------------------------------------------
// fmpf_pkg
// Types and constants shared by the first-match packet filter modules.
// ----------------------------------------------------------------------------
package fmpf_pkg;

    // operation codes as carried on the input tuser
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] DIR_ANY  = 2'd2;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_ADDR_W = 3;

    // register indexes (paddr[2])
    localparam logic CFG_FILTER_ON  = 1'b0;
    localparam logic CFG_MISS_ALLOW = 1'b1;

    typedef enum logic [1:0] {
        K_CHECK = 2'd0,
        K_ADD   = 2'd1,
        K_CLEAR = 2'd2,
        K_NOP   = 2'd3
    } kind_t;

    // one rule, or the packet fields of a check item
    typedef struct packed {
        logic [31:0] mask;
        logic [15:0] port;
        logic        port_used;
        logic        addr_used;
        logic [7:0]  proto;
        logic        action;
        logic [1:0]  dir;
        logic [31:0] addr;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    typedef struct packed {
        kind_t kind;
        rule_t rule;
    } cmd_t;

endpackage

/* sv/fmpf_ram.sv */
// ----------------------------------------------------------------------------
// fmpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmpf_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/fmpf_front.sv */
// ----------------------------------------------------------------------------
// fmpf_front
// Accepts input items, classifies the operation and queues commands.
// ----------------------------------------------------------------------------
module fmpf_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [fmpf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]                     s_axis_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_pop,
    output fmpf_pkg::cmd_t                 cmd
);

    fmpf_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    fmpf_pkg::cmd_t in_cmd;
    logic           push;

    always_comb
    begin
        in_cmd.rule.dir       = s_axis_tdata[1:0];
        in_cmd.rule.proto     = s_axis_tdata[9:2];
        in_cmd.rule.addr      = s_axis_tdata[41:10];
        in_cmd.rule.port      = s_axis_tdata[57:42];
        in_cmd.rule.action    = s_axis_tdata[58];
        in_cmd.rule.addr_used = s_axis_tdata[59];
        in_cmd.rule.port_used = s_axis_tdata[60];
        in_cmd.rule.mask      = s_axis_tdata[92:61];
        unique case (s_axis_tuser)
            fmpf_pkg::OP_CHECK: in_cmd.kind = fmpf_pkg::K_CHECK;
            fmpf_pkg::OP_ADD:   in_cmd.kind = fmpf_pkg::K_ADD;
            fmpf_pkg::OP_CLEAR: in_cmd.kind = fmpf_pkg::K_CLEAR;
            default:            in_cmd.kind = fmpf_pkg::K_NOP;
        endcase
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (cnt_reg != 2'd0);
    assign cmd           = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, cmd_pop && cmd_valid})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* sv/fmpf_back.sv */
// ----------------------------------------------------------------------------
// fmpf_back
// Executes queued commands: rule table, first-match scan, counters, result.
// ----------------------------------------------------------------------------
module fmpf_back #(
    parameter int  RULE_SLOTS = 32,
    localparam int ADDR_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            filter_on,
    input  logic                            miss_allow,
    input  logic                            cmd_valid,
    output logic                            cmd_pop,
    input  fmpf_pkg::cmd_t                  cmd,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fmpf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          total_reg, total_next;
    logic [CNT_W-1:0]          scan_idx_reg, scan_idx_next;
    logic                      pend_reg, pend_next;
    logic [31:0]               pass_reg, pass_next;
    logic [31:0]               block_reg, block_next;
    fmpf_pkg::rule_t           pkt_reg, pkt_next;
    logic                      allow_reg, allow_next;
    logic                      status_reg, status_next;

    logic                      issue;
    logic                      wr_en;
    logic [fmpf_pkg::RULE_W-1:0] rd_data;
    fmpf_pkg::rule_t           rule;
    logic                      hit;
    logic                      verdict;
    logic                      finish;
    logic [CNT_W+5:0]          total_ext;

    fmpf_ram #(
        .WIDTH (fmpf_pkg::RULE_W),
        .DEPTH (RULE_SLOTS)
    ) u_rules (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (total_reg[ADDR_W-1:0]),
        .wr_data (cmd.rule),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign rule  = fmpf_pkg::rule_t'(rd_data);
    assign issue = (state_reg == ST_SCAN) && (scan_idx_reg < total_reg);

    always_comb
    begin
        hit = 1'b1;
        if ((rule.dir != fmpf_pkg::DIR_ANY) && (rule.dir != pkt_reg.dir))
        begin
            hit = 1'b0;
        end
        if ((rule.proto != 8'd0) && (rule.proto != pkt_reg.proto))
        begin
            hit = 1'b0;
        end
        if (rule.addr_used && ((pkt_reg.addr & rule.mask) != (rule.addr & rule.mask)))
        begin
            hit = 1'b0;
        end
        if (rule.port_used && (rule.port != pkt_reg.port))
        begin
            hit = 1'b0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = pend_reg;
        pass_next     = pass_reg;
        block_next    = block_reg;
        pkt_next      = pkt_reg;
        allow_next    = allow_reg;
        status_next   = status_reg;
        cmd_pop       = 1'b0;
        wr_en         = 1'b0;
        finish        = 1'b0;
        verdict       = miss_allow;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    allow_next  = 1'b0;
                    status_next = 1'b0;
                    state_next  = ST_OUT;
                    unique case (cmd.kind)
                        fmpf_pkg::K_CHECK:
                        begin
                            if (filter_on)
                            begin
                                state_next    = ST_SCAN;
                                scan_idx_next = '0;
                                pend_next     = 1'b0;
                                pkt_next      = cmd.rule;
                            end
                            else
                            begin
                                allow_next = 1'b1;
                            end
                        end
                        fmpf_pkg::K_ADD:
                        begin
                            if (total_reg >= CNT_W'(RULE_SLOTS))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                total_next = total_reg + CNT_W'(1);
                            end
                        end
                        fmpf_pkg::K_CLEAR:
                        begin
                            total_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // reads are pipelined: rule k is compared while k+1 is read
                pend_next = issue;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (pend_reg && hit)
                begin
                    verdict = rule.action;
                    finish  = 1'b1;
                end
                else if (!issue)
                begin
                    finish = 1'b1;
                end
                if (finish)
                begin
                    allow_next = verdict;
                    state_next = ST_OUT;
                    if (verdict)
                    begin
                        pass_next = pass_reg + 32'd1;
                    end
                    else
                    begin
                        block_next = block_reg + 32'd1;
                    end
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            pend_reg  <= 1'b0;
            pass_reg  <= 32'd0;
            block_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
            pass_reg  <= pass_next;
            block_reg <= block_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        pkt_reg      <= pkt_next;
        allow_reg    <= allow_next;
        status_reg   <= status_next;
    end

    // counters and table size hold while the result waits
    assign total_ext     = {6'd0, total_reg};
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {total_ext[5:0], block_reg, pass_reg, status_reg, allow_reg};

endmodule

/* sv/first_match_packet_filter_core.sv */
// ----------------------------------------------------------------------------
// first_match_packet_filter_core
// First-match packet filter: rule table, packet checks, pass/block counters.
// ----------------------------------------------------------------------------
// channel   | direction | contents
// s_axis    | in        | tdata: direction, protocol, remote_addr, remote_port,
//           |           |   rule_allow, addr_used, port_used, addr_mask
//           |           | tuser: operation
// m_axis    | out       | tdata: allow, status, passed_total, blocked_total,
//           |           |   rules_in_use
// apb       | in/out    | filter_on at 0x0, miss_allow at 0x4
//
// A check with filtering on reads rules in table order from the rule RAM, one
// rule read per cycle, until the first hit (all N in use on a miss); other
// items skip the scan and go straight to the result.
// Items are queued two deep ahead of the execution engine, one item in flight.
// Reset is asynchronous; the table comes up empty with no clearing pass.
// A stalled result holds the engine; input keeps filling the queue.
// ----------------------------------------------------------------------------
module first_match_packet_filter_core #(
    parameter int RULE_SLOTS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // [1:0] direction, [9:2] protocol, [41:10] remote_addr, [57:42] remote_port,
    // [58] rule_allow, [59] addr_used, [60] port_used, [92:61] addr_mask
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fmpf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]                      s_axis_tuser,
    // [0] allow, [1] status, [33:2] passed_total, [65:34] blocked_total,
    // [71:66] rules_in_use
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fmpf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fmpf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic           filter_on_reg;
    logic           miss_allow_reg;
    logic           cfg_wr;
    logic           cmd_valid;
    logic           cmd_pop;
    fmpf_pkg::cmd_t cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_on_reg  <= 1'b0;
            miss_allow_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                fmpf_pkg::CFG_FILTER_ON:  filter_on_reg  <= pwdata[0];
                fmpf_pkg::CFG_MISS_ALLOW: miss_allow_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fmpf_pkg::CFG_FILTER_ON:  prdata = {31'd0, filter_on_reg};
            fmpf_pkg::CFG_MISS_ALLOW: prdata = {31'd0, miss_allow_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    fmpf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd)
    );

    fmpf_back #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .filter_on     (filter_on_reg),
        .miss_allow    (miss_allow_reg),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* sv/fmpf_checker.sv */
// ----------------------------------------------------------------------------
// fmpf_checker
// Port-level checks for the first-match packet filter, bound to the top level.
// ----------------------------------------------------------------------------
module fmpf_checker #(
    parameter int RULE_SLOTS = 32
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fmpf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [5:0] FULL_COUNT = 6'(RULE_SLOTS);

    // a refused add never carries a pass verdict
    a_refused_not_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
        else $error("refused add reports allow");

    // a refused add only happens with a full table
    a_refused_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[71:66] == FULL_COUNT)
        else $error("add refused while table not full");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind first_match_packet_filter_core fmpf_checker #(.RULE_SLOTS(RULE_SLOTS)) u_fmpf_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-match packet filter core. Items come from
// a queue that the stimulus process fills per phase. Each accepted item runs
// through a behavioral copy of the rule table and counters. Each result is
// checked, field by field, against the oldest predicted one. Phases change
// the filter registers over APB while idle and vary the stream back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import fmpf_pkg::*;

    localparam int RULE_SLOTS = 32;

    localparam logic [1:0] DIR_IN   = 2'd0;
    localparam logic [1:0] DIR_OUT  = 2'd1;
    localparam logic [1:0] DIR_RSVD = 2'd3;

    localparam logic [7:0] PROTO_WILD = 8'd0;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // per random phase: filter_on and miss_allow, bit n for phase n
    localparam logic [5:0] PHASE_FILTER_ON = 6'b011011;
    localparam logic [5:0] PHASE_DEF_ALLOW = 6'b010101;
    localparam int         PHASE_ITEMS     = 200;
    localparam int         HOLD_CYCLES     = 400;

    typedef struct packed {
        logic [5:0]  rules;
        logic [31:0] blocked;
        logic [31:0] passed;
        logic        status;
        logic        allow;
    } filt_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    first_match_packet_filter_core #(.RULE_SLOTS(RULE_SLOTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // stimulus side
    cmd_t  item_q[$];
    rule_t planned_rules[$];
    int    issued_cnt = 0;
    int    episode_no = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    logic  hold_armed = 1'b0;
    logic  hold_done = 1'b0;
    int    hold_left = 0;

    // checking side
    rule_t        tab_rules[RULE_SLOTS];
    int           tab_count = 0;
    logic [31:0]  pass_total = '0;
    logic [31:0]  block_total = '0;
    logic         cfg_filter_on = 1'b0;
    logic         cfg_miss_allow = 1'b1;
    filt_result_t pending_results[$];
    int           accepted_cnt = 0;
    int           mismatches = 0;
    logic         in_fire = 1'b0;

    function automatic logic [IN_DATA_W-1:0] pack_item(cmd_t c);
        return {3'b000, c.rule.mask, c.rule.port_used, c.rule.addr_used, c.rule.action,
                c.rule.port, c.rule.addr, c.rule.proto, c.rule.dir};
    endfunction

    function automatic cmd_t unpack_item(logic [IN_DATA_W-1:0] d, logic [1:0] u);
        cmd_t c;
        c.kind           = kind_t'(u);
        c.rule.dir       = d[1:0];
        c.rule.proto     = d[9:2];
        c.rule.addr      = d[41:10];
        c.rule.port      = d[57:42];
        c.rule.action    = d[58];
        c.rule.addr_used = d[59];
        c.rule.port_used = d[60];
        c.rule.mask      = d[92:61];
        return c;
    endfunction

    // behavioral filter: updates table and counters, returns the result
    function automatic filt_result_t filter_apply(cmd_t c);
        filt_result_t res;
        rule_t        r;
        logic         hit;
        res = '0;
        case (c.kind)
            K_CHECK:
            begin
                if (!cfg_filter_on)
                    res.allow = 1'b1;
                else
                begin
                    hit = 1'b0;
                    res.allow = cfg_miss_allow;
                    for (int k = 0; k < tab_count && !hit; k++)
                    begin
                        r = tab_rules[k];
                        if ((r.dir == DIR_ANY || r.dir == c.rule.dir) &&
                            (r.proto == PROTO_WILD || r.proto == c.rule.proto) &&
                            (!r.addr_used || ((c.rule.addr ^ r.addr) & r.mask) == 32'd0) &&
                            (!r.port_used || r.port == c.rule.port))
                        begin
                            hit = 1'b1;
                            res.allow = r.action;
                        end
                    end
                    if (res.allow)
                        pass_total = pass_total + 32'd1;
                    else
                        block_total = block_total + 32'd1;
                end
            end
            K_ADD:
            begin
                if (tab_count >= RULE_SLOTS)
                    res.status = 1'b1;
                else
                begin
                    tab_rules[tab_count] = c.rule;
                    tab_count++;
                end
            end
            K_CLEAR:
                tab_count = 0;
            default: ;
        endcase
        res.passed  = pass_total;
        res.blocked = block_total;
        res.rules   = 6'(tab_count);
        return res;
    endfunction

    function automatic string show_result(filt_result_t r);
        return $sformatf("allow=%0d status=%0d passed=%0d blocked=%0d rules=%0d",
                         r.allow, r.status, r.passed, r.blocked, r.rules);
    endfunction

    // ---------------- item generation ----------------

    function automatic cmd_t random_fields(kind_t k);
        cmd_t c;
        c.kind           = k;
        c.rule.dir       = 2'($urandom_range(3));
        c.rule.proto     = 8'($urandom_range(255));
        c.rule.addr      = $urandom;
        c.rule.port      = 16'($urandom_range(65535));
        c.rule.action    = 1'($urandom_range(1));
        c.rule.addr_used = 1'($urandom_range(1));
        c.rule.port_used = 1'($urandom_range(1));
        c.rule.mask      = $urandom;
        return c;
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(7))
            0: return 16'd22;
            1: return 16'd53;
            2: return 16'd80;
            3: return 16'd443;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic cmd_t mk(kind_t k, logic [1:0] d, logic [7:0] p, logic [31:0] a,
                                logic [15:0] pt, logic act, logic au, logic pu,
                                logic [31:0] m);
        cmd_t c;
        c.kind = k;
        c.rule = '{mask: m, port: pt, port_used: pu, addr_used: au, proto: p,
                   action: act, dir: d, addr: a};
        return c;
    endfunction

    function automatic cmd_t make_rule();
        cmd_t c;
        int   sel;
        c = random_fields(K_ADD);
        sel = $urandom_range(9);
        c.rule.dir = (sel < 3) ? DIR_IN : (sel < 6) ? DIR_OUT : (sel < 9) ? DIR_ANY : DIR_RSVD;
        sel = $urandom_range(9);
        if (sel < 4)
            c.rule.proto = PROTO_WILD;
        else if (sel < 5)
            c.rule.proto = PROTO_ICMP;
        else if (sel < 6)
            c.rule.proto = PROTO_TCP;
        else if (sel < 7)
            c.rule.proto = PROTO_UDP;
        // CIDR prefix most of the time, an arbitrary mask otherwise
        if ($urandom_range(99) < 85)
            c.rule.mask = 32'hFFFF_FFFF << (32 - $urandom_range(32));
        c.rule.port = pick_port();
        return c;
    endfunction

    function automatic cmd_t make_check();
        cmd_t  c;
        rule_t r;
        c = random_fields(K_CHECK);
        if (planned_rules.size() > 0 && $urandom_range(99) < 65)
        begin
            // aim at a stored rule, sometimes just missing it
            r = planned_rules[$urandom_range(planned_rules.size() - 1)];
            if (r.dir != DIR_ANY)
                c.rule.dir = r.dir;
            if (r.proto != PROTO_WILD)
                c.rule.proto = r.proto;
            c.rule.addr = (r.addr & r.mask) | (c.rule.addr & ~r.mask);
            c.rule.port = r.port;
            if ($urandom_range(99) < 30)
            begin
                case ($urandom_range(3))
                    0: c.rule.dir = c.rule.dir ^ 2'd1;
                    1: c.rule.proto = c.rule.proto ^ 8'd1;
                    2: c.rule.addr = c.rule.addr ^ (32'd1 << $urandom_range(31));
                    default: c.rule.port = c.rule.port + 16'd1;
                endcase
            end
        end
        else
            c.rule.port = pick_port();
        return c;
    endfunction

    task automatic push_item(cmd_t c);
        item_q.push_back(c);
        issued_cnt++;
        if (c.kind == K_ADD && planned_rules.size() < RULE_SLOTS)
            planned_rules.push_back(c.rule);
        else if (c.kind == K_CLEAR)
            planned_rules.delete();
    endtask

    // clear, build a table (every third one aimed at or past full), then traffic
    task automatic run_episode();
        int n_add;
        int n_chk;
        int sel;
        push_item(random_fields(K_CLEAR));
        n_add = (episode_no % 3 == 0) ? $urandom_range(37, 32) : $urandom_range(12, 0);
        n_chk = $urandom_range(30, 8);
        episode_no++;
        repeat (n_add)
        begin
            if ($urandom_range(19) == 0)
                push_item(make_check());
            else
                push_item(make_rule());
        end
        repeat (n_chk)
        begin
            sel = $urandom_range(99);
            if (sel < 85)
                push_item(make_check());
            else if (sel < 92)
                push_item(make_rule());
            else if (sel < 97)
                push_item(random_fields(K_NOP));
            else
                push_item(random_fields(K_CLEAR));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (accepted_cnt != issued_cnt || pending_results.size() != 0)
            @(negedge clk);
    endtask

    // APB write, then read back
    task automatic set_reg(logic idx, logic val);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == CFG_FILTER_ON)
            cfg_filter_on = val;
        else
            cfg_miss_allow = val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {31'd0, val})
        begin
            if (mismatches < 10)
                $display("%0t: register %0d read back %h, wrote %0d", $time, idx, rd, val);
            mismatches++;
        end
    endtask

    // ---------------- driver / receiver / monitor ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_fire)
        begin
            if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata  <= pack_item(item_q[0]);
                s_axis_tuser  <= item_q[0].kind;
                s_axis_tvalid <= 1'b1;
                void'(item_q.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            // long back-pressure so the input queue fills up
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        filt_result_t got;
        filt_result_t want;
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pending_results.push_back(filter_apply(unpack_item(s_axis_tdata, s_axis_tuser)));
            accepted_cnt++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected result %s", $time, show_result(got));
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.allow !== want.allow || got.status !== want.status ||
                    got.passed !== want.passed || got.blocked !== want.blocked ||
                    got.rules !== want.rules)
                begin
                    if (mismatches < 10)
                        $display("%0t: mismatch\n  exp %s\n  got %s", $time,
                                 show_result(want), show_result(got));
                    mismatches++;
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 77;

        // reset settings: filter off, every check passes uncounted
        push_item(mk(K_CHECK, DIR_IN, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_CHECK, DIR_RSVD, 8'hFF, '1, '1, 1'b1, 1'b1, 1'b1, '1));
        push_item(mk(K_ADD, DIR_RSVD, 8'hFF, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_NOP, DIR_RSVD, 8'hFF, '1, '1, 1'b1, 1'b1, 1'b1, '1));
        push_item(mk(K_CHECK, DIR_RSVD, 8'hFF, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_CLEAR, DIR_IN, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        drain();

        set_reg(CFG_FILTER_ON, 1'b1);
        set_reg(CFG_MISS_ALLOW, 1'b1);
        push_item(mk(K_CHECK, DIR_IN, PROTO_TCP, 32'h0A00_0001, 16'd80,
                     1'b0, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_ADD, DIR_IN, PROTO_TCP, 32'h0A00_0000, 16'd80,
                     1'b0, 1'b1, 1'b1, 32'hFF00_0000));
        push_item(mk(K_ADD, DIR_RSVD, PROTO_WILD, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_ADD, DIR_OUT, PROTO_UDP, 32'd0, 16'd53, 1'b1, 1'b0, 1'b1, 32'd0));
        push_item(mk(K_ADD, DIR_ANY, PROTO_WILD, 32'hC0A8_0000, 16'd0,
                     1'b0, 1'b1, 1'b0, 32'hFFFF_0000));
        push_item(mk(K_CHECK, DIR_IN, PROTO_TCP, 32'h0A12_3456, 16'd80,
                     1'b1, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_CHECK, DIR_IN, PROTO_TCP, 32'h0B00_0000, 16'd80,
                     1'b0, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_CHECK, DIR_IN, PROTO_UDP, 32'h0A00_0001, 16'd80,
                     1'b0, 1'b0, 1'b0, 32'd0));
        // packet direction 3 hits the direction-3 rule
        push_item(mk(K_CHECK, DIR_RSVD, 8'd99, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_CHECK, DIR_OUT, PROTO_UDP, 32'h0102_0304, 16'd53,
                     1'b0, 1'b0, 1'b0, 32'd0));
        // packet direction "any" only meets the wildcard rule
        push_item(mk(K_CHECK, DIR_ANY, PROTO_ICMP, 32'hC0A8_0101, 16'd0,
                     1'b1, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_CHECK, DIR_OUT, PROTO_UDP, 32'hC0A8_FFFF, 16'd54,
                     1'b1, 1'b0, 1'b0, 32'd0));
        // zero mask with address compare on: matches any address
        push_item(mk(K_ADD, DIR_IN, PROTO_WILD, 32'hFFFF_FFFF, 16'd0,
                     1'b1, 1'b1, 1'b1, 32'd0));
        push_item(mk(K_CHECK, DIR_IN, 8'd200, 32'hFFFF_FFFF, 16'd0,
                     1'b0, 1'b0, 1'b0, 32'd0));
        drain();

        set_reg(CFG_MISS_ALLOW, 1'b0);
        push_item(mk(K_CHECK, DIR_OUT, PROTO_TCP, 32'h0102_0304, 16'd1234,
                     1'b1, 1'b1, 1'b1, '1));
        push_item(mk(K_CLEAR, DIR_IN, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        push_item(mk(K_CHECK, DIR_IN, PROTO_TCP, 32'h0A00_0001, 16'd80,
                     1'b1, 1'b0, 1'b0, 32'd0));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 77 : 0;
            recv_idle_pct = (ph < 2) ? 77 : (ph < 4) ? 37 : 0;
            set_reg(CFG_FILTER_ON, PHASE_FILTER_ON[ph]);
            set_reg(CFG_MISS_ALLOW, PHASE_DEF_ALLOW[ph]);
            if (ph == 4)
                hold_armed = 1'b1;
            begin : fill
                int start;
                start = issued_cnt;
                while (issued_cnt - start < PHASE_ITEMS)
                    run_episode();
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
